### rtl/scd_pkg.sv
// shared types, constants and q31 helpers for the stereo chorus delay
package scd_pkg;

  // default ring depth per channel
  localparam int RING_DEPTH_DEF = 1024;

  // lowpass coefficients, tap gain and one minus that gain
  localparam logic signed [32:0] LPF_GAIN = 33'sh59999999;
  localparam logic signed [32:0] LPF_REST = 33'sh26666666;

  // q31 limits
  localparam logic signed [31:0] Q31_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q31_MIN = 32'sh80000000;

  // configuration register indexes
  localparam logic [2:0] REG_MOD_DEPTH     = 3'd0;
  localparam logic [2:0] REG_FEEDBACK_GAIN = 3'd1;
  localparam logic [2:0] REG_WET_MIX       = 3'd2;
  localparam logic [2:0] REG_LFO_STEP      = 3'd3;
  localparam logic [2:0] REG_MIN_DELAY     = 3'd4;
  localparam logic [2:0] REG_DELAY_SPAN    = 3'd5;

  // configuration reset values
  localparam logic signed [31:0] MOD_DEPTH_RST     = 32'sh20000000;
  localparam logic signed [31:0] FEEDBACK_GAIN_RST = 32'sh20000000;
  localparam logic [30:0]        WET_MIX_RST       = 31'h30000000;
  localparam logic [15:0]        LFO_STEP_RST      = 16'd1;
  localparam logic [9:0]         MIN_DELAY_RST     = 10'd600;
  localparam logic [9:0]         DELAY_SPAN_RST    = 10'd300;

  // lfo phase reset, right channel a quarter turn ahead
  localparam logic [15:0] PHASE_LEFT_RST  = 16'h0000;
  localparam logic [15:0] PHASE_RIGHT_RST = 16'h4000;

  // full product of the shared multiplier
  typedef logic signed [65:0] prod_t;

  // triangle lfo from a 16-bit phase
  function automatic logic signed [31:0] triangle(input logic [15:0] phase);
    logic [31:0] up;
    logic [31:0] down;
    up   = {1'b0, phase[13:0], 17'b0};
    down = {1'b0, ~phase[13:0], 17'b0};
    case (phase[15:14])
      2'd0:    triangle = up;
      2'd1:    triangle = down;
      2'd2:    triangle = -up;
      default: triangle = -down;
    endcase
  endfunction

  // q31 product: floor by 2^31, then saturate
  function automatic logic signed [31:0] qsat(input prod_t p);
    if (p[65:62] == 4'b0000 || p[65:62] == 4'b1111) begin
      qsat = p[62:31];
    end else if (p[65]) begin
      qsat = Q31_MIN;
    end else begin
      qsat = Q31_MAX;
    end
  endfunction

  // saturating add of two q31 values
  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      qadd = s[32] ? Q31_MIN : Q31_MAX;
    end else begin
      qadd = s[31:0];
    end
  endfunction

endpackage

### rtl/stereo_chorus_delay.sv
// stereo chorus: modulated delay line with lowpass feedback, one per channel
// sequencing: one accept step in idle, then fifteen sequencer steps around one
//   shared 33x33 multiplier and the ring read port
// requests: taken only in idle, once the last sample has left the final step;
//   the next request is taken while a result still waits in the output register
// reset: synchronous; registers, lfo phases, filters and write pointers return to
//   defaults at once; ring entries not yet written since reset read as zero
module stereo_chorus_delay
  import scd_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               channel_select,
  input  logic signed [31:0] sample_in,
  // result requests
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] sample_out,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = (AW + 1 > 12) ? AW + 1 : 12;
  localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(RING_DEPTH);
  localparam logic [CW-1:0] DMAX_X   = CW'(RING_DEPTH - 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LFO  = 4'd1;
  localparam logic [3:0] S_UNI  = 4'd2;
  localparam logic [3:0] S_SPAN = 4'd3;
  localparam logic [3:0] S_ADDR = 4'd4;
  localparam logic [3:0] S_RD0  = 4'd5;
  localparam logic [3:0] S_RD1  = 4'd6;
  localparam logic [3:0] S_DIFF = 4'd7;
  localparam logic [3:0] S_TAP  = 4'd8;
  localparam logic [3:0] S_LP1  = 4'd9;
  localparam logic [3:0] S_LP2  = 4'd10;
  localparam logic [3:0] S_LP3  = 4'd11;
  localparam logic [3:0] S_FB   = 4'd12;
  localparam logic [3:0] S_WR   = 4'd13;
  localparam logic [3:0] S_MIX1 = 4'd14;
  localparam logic [3:0] S_MIX2 = 4'd15;

  logic [3:0] state;

  // configuration registers
  logic signed [31:0] mod_depth;
  logic signed [31:0] feedback_gain;
  logic [30:0]        wet_mix;
  logic [15:0]        lfo_step;
  logic [9:0]         min_delay;
  logic [9:0]         delay_span;

  // per channel state
  logic [AW-1:0]      wptr    [2];
  logic               wrapped [2];
  logic signed [31:0] smooth  [2];
  logic [15:0]        phase   [2];

  // item registers
  logic               ch;
  logic signed [31:0] x;
  prod_t              prod;
  logic [30:0]        uni;
  logic [15:0]        frac;
  logic [AW-1:0]      delay;
  logic [AW-1:0]      i0;
  logic signed [31:0] s0;
  logic signed [31:0] tap;
  logic signed [31:0] acc;
  logic signed [31:0] delayed;

  // ring memories and read path
  logic [31:0]        ring_left  [RING_DEPTH];
  logic [31:0]        ring_right [RING_DEPTH];
  logic [31:0]        rd_left;
  logic [31:0]        rd_right;
  logic               rd_ok;

  // combinational
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [31:0] pq;
  logic signed [31:0] lfo_val;
  logic [31:0]        uni_full;
  logic [CW-1:0]      delay_sum;
  logic [AW:0]        i0_sum;
  logic [AW-1:0]      i0_next;
  logic [AW-1:0]      i1_next;
  logic [AW-1:0]      raddr;
  logic signed [31:0] rd_s;
  logic signed [31:0] wr_data;
  logic               we;
  logic               out_busy;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_busy  = out_valid && out_stall;

  // q31 view of the last product
  assign pq = qsat(prod);

  // triangle value of the current channel phase
  assign lfo_val = triangle(phase[ch]);

  // unipolar modulation value
  assign uni_full = {pq[31], pq[31:1]} + 32'h40000000;

  // tap delay from the integer part of the span product
  assign delay_sum = CW'(min_delay) + CW'(prod[41:31]);

  // read slots: older tap and the next newer one
  assign i0_sum  = {1'b0, wptr[ch]} + (DEPTH_X - {1'b0, delay});
  assign i0_next = (i0_sum >= DEPTH_X) ? AW'(i0_sum - DEPTH_X) : i0_sum[AW-1:0];
  assign i1_next = (i0 == LAST_IDX) ? '0 : i0 + 1'b1;
  assign raddr   = (state == S_RD0) ? i0_next : i1_next;

  // unwritten entries read as zero
  assign rd_s = rd_ok ? (ch ? rd_right : rd_left) : 32'sd0;

  // value written back into the ring
  assign wr_data = qadd(x, pq);
  assign we      = (state == S_WR);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_LFO: begin
        mul_a = {lfo_val[31], lfo_val};
        mul_b = {mod_depth[31], mod_depth};
      end
      S_SPAN: begin
        mul_a = {2'b00, uni};
        mul_b = {23'd0, delay_span};
      end
      S_DIFF: begin
        mul_a = {17'd0, frac};
        mul_b = {rd_s[31], rd_s} - {s0[31], s0};
      end
      S_LP1: begin
        mul_a = {tap[31], tap};
        mul_b = LPF_GAIN;
      end
      S_LP2: begin
        mul_a = {smooth[ch][31], smooth[ch]};
        mul_b = LPF_REST;
      end
      S_FB: begin
        mul_a = {delayed[31], delayed};
        mul_b = {feedback_gain[31], feedback_gain};
      end
      S_WR: begin
        mul_a = {x[31], x};
        mul_b = {2'b00, ~wet_mix};
      end
      // wet product held while the result waits
      S_MIX1, S_MIX2: begin
        mul_a = {delayed[31], delayed};
        mul_b = {2'b00, wet_mix};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // product register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // ring memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (we && !ch) begin
      ring_left[wptr[ch]] <= wr_data;
    end
    rd_left <= ring_left[raddr];
  end

  always_ff @(posedge clk) begin
    if (we && ch) begin
      ring_right[wptr[ch]] <= wr_data;
    end
    rd_right <= ring_right[raddr];
  end

  // fill tracking for the slot being read
  always_ff @(posedge clk) begin
    rd_ok <= wrapped[ch] || (raddr < wptr[ch]);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_depth     <= MOD_DEPTH_RST;
      feedback_gain <= FEEDBACK_GAIN_RST;
      wet_mix       <= WET_MIX_RST;
      lfo_step      <= LFO_STEP_RST;
      min_delay     <= MIN_DELAY_RST;
      delay_span    <= DELAY_SPAN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MOD_DEPTH:     mod_depth     <= cfg_data;
        REG_FEEDBACK_GAIN: feedback_gain <= cfg_data;
        REG_WET_MIX:       wet_mix       <= cfg_data[30:0];
        REG_LFO_STEP:      lfo_step      <= cfg_data[15:0];
        REG_MIN_DELAY:     min_delay     <= cfg_data[9:0];
        REG_DELAY_SPAN:    delay_span    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // per channel state: phase, filter, write pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase[0]   <= PHASE_LEFT_RST;
      phase[1]   <= PHASE_RIGHT_RST;
      smooth[0]  <= '0;
      smooth[1]  <= '0;
      wptr[0]    <= '0;
      wptr[1]    <= '0;
      wrapped[0] <= 1'b0;
      wrapped[1] <= 1'b0;
    end else begin
      if (state == S_LFO) begin
        phase[ch] <= phase[ch] + lfo_step;
      end
      if (state == S_LP3) begin
        smooth[ch] <= qadd(acc, pq);
      end
      if (we) begin
        if (wptr[ch] == LAST_IDX) begin
          wptr[ch]    <= '0;
          wrapped[ch] <= 1'b1;
        end else begin
          wptr[ch] <= wptr[ch] + 1'b1;
        end
      end
    end
  end

  // item datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ch <= channel_select;
        x  <= sample_in;
      end
      S_UNI:  uni <= uni_full[30:0];
      S_ADDR: begin
        frac  <= prod[30:15];
        delay <= (delay_sum > DMAX_X) ? LAST_IDX : delay_sum[AW-1:0];
      end
      S_RD0:  i0 <= i0_next;
      S_RD1:  s0 <= rd_s;
      S_TAP:  tap <= s0 + prod[47:16];
      S_LP2:  acc <= pq;
      S_LP3:  delayed <= qadd(acc, pq);
      S_MIX1: acc <= pq;
      S_MIX2: begin
        if (!out_busy) begin
          sample_out <= qadd(acc, pq);
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_LFO;
          end
        end
        S_MIX2: begin
          if (!out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= state + 4'd1;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_MIX2 && !out_busy) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### sim/tb_stereo_chorus_delay.sv
// self-checking testbench for the stereo chorus delay, with its own chorus predictor
`timescale 1ns / 1ps

module tb_stereo_chorus_delay;
  import scd_pkg::*;

  localparam int RING_LEN = RING_DEPTH_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 216;
  localparam longint LFO_OFS_MAX = 'h3FFF;
  localparam logic signed [31:0] LPF_A = 32'sh59999999;
  localparam logic signed [31:0] LPF_B = 32'sh26666666;
  // indexes beyond the register file, writes there change nothing
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic ch;
    logic signed [31:0] smp;
  } chorus_req_t;

  // clock, reset and block ports
  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic channel_select = 1'b0;
  logic signed [31:0] sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor state per channel
  logic signed [31:0] ring [2][RING_LEN];
  int wptr [2];
  logic signed [31:0] smooth [2];
  logic [15:0] lfo_phase [2];

  // predictor copy of the registers
  logic signed [31:0] md_r;
  logic signed [31:0] fg_r;
  logic [30:0] wet_r;
  logic [15:0] step_r;
  int mind_r;
  int span_r;

  // stimulus and checking bookkeeping
  chorus_req_t pending_reqs[$];
  logic signed [31:0] expected_outs[$];
  chorus_req_t next_req;
  logic signed [31:0] want;
  logic tx_gaps = 1'b1;
  logic rx_gaps = 1'b1;
  logic hold_off = 1'b0;
  int tx_wait = 0;
  int stall_run = 0;
  int accepted_total = 0;
  int results_seen = 0;
  int fail_count = 0;
  int setting_count = 0;

  stereo_chorus_delay DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .channel_select (channel_select),
    .sample_in      (sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sample_out     (sample_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // clip a wide value into q31 range
  function automatic logic signed [31:0] q31_clip(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // fractional multiply, floored, saturated
  function automatic logic signed [31:0] q31_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return q31_clip(p >>> 31);
  endfunction

  function automatic logic signed [31:0] q31_sum(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return q31_clip(longint'(a) + longint'(b));
  endfunction

  // triangle wave over four quarters of the phase
  function automatic logic signed [31:0] lfo_wave(input logic [15:0] ph);
    longint o;
    longint v;
    o = ph[13:0];
    case (ph[15:14])
      2'd0:    v = o * 131072;
      2'd1:    v = (LFO_OFS_MAX - o) * 131072;
      2'd2:    v = -(o * 131072);
      default: v = -((LFO_OFS_MAX - o) * 131072);
    endcase
    return v[31:0];
  endfunction

  // one sample through the chorus: tap, lowpass, feedback write, dry/wet mix
  function automatic logic signed [31:0] chorus_predict(input logic ch,
                                                        input logic signed [31:0] x);
    logic signed [31:0] lfo;
    logic signed [31:0] scaled;
    logic signed [31:0] tap;
    logic signed [31:0] delayed;
    logic signed [31:0] dry_gain;
    longint uni;
    longint t;
    longint frac;
    longint s0;
    longint s1;
    int dly;
    int i0;
    int i1;
    lfo = lfo_wave(lfo_phase[ch]);
    lfo_phase[ch] = lfo_phase[ch] + step_r;
    scaled = q31_mul(lfo, md_r);
    uni = (longint'(scaled) >>> 1) + 64'sh40000000;
    t = uni * longint'(span_r);
    frac = (t >> 15) & 'hFFFF;
    dly = mind_r + int'(t >> 31);
    if (dly > RING_LEN - 1) dly = RING_LEN - 1;
    i0 = (wptr[ch] + RING_LEN - dly) % RING_LEN;
    i1 = (i0 + 1) % RING_LEN;
    s0 = ring[ch][i0];
    s1 = ring[ch][i1];
    tap = 32'(s0 + ((frac * (s1 - s0)) >>> 16));
    delayed = q31_sum(q31_mul(tap, LPF_A), q31_mul(smooth[ch], LPF_B));
    smooth[ch] = delayed;
    ring[ch][wptr[ch]] = q31_sum(x, q31_mul(delayed, fg_r));
    wptr[ch] = (wptr[ch] + 1) % RING_LEN;
    dry_gain = 32'h7FFFFFFF - {1'b0, wet_r};
    return q31_sum(q31_mul(x, dry_gain), q31_mul(delayed, {1'b0, wet_r}));
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 80);
  endfunction

  // random sample, weighted toward the extremes
  function automatic logic signed [31:0] rand_sample();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0:       return Q31_MAX;
      1:       return Q31_MIN;
      2:       return '0;
      3:       return -32'sd1;
      4, 5:    return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_req(input logic c, input logic signed [31:0] s);
    pending_reqs.push_back('{ch: c, smp: s});
  endtask

  // mostly stereo pairs, left then right, with single stray samples mixed in
  task automatic queue_random(input int count);
    int queued;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(0, 3) != 0) begin
        queue_req(1'b0, rand_sample());
        queue_req(1'b1, rand_sample());
        queued += 2;
      end else begin
        queue_req(1'($urandom_range(0, 1)), rand_sample());
        queued++;
      end
    end
  endtask

  // model side of a register write
  task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      REG_MOD_DEPTH:     md_r = val;
      REG_FEEDBACK_GAIN: fg_r = val;
      REG_WET_MIX:       wet_r = val[30:0];
      REG_LFO_STEP:      step_r = val[15:0];
      REG_MIN_DELAY:     mind_r = val[9:0];
      REG_DELAY_SPAN:    span_r = val[9:0];
      default: ;
    endcase
  endtask

  // one register write; valid stays up so writes can go back to back
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    set_reg(idx, val);
  endtask

  // wait until every request went through and every result came back
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_outs.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // drain, then write the whole register file
  task automatic settle_and_write(input logic [31:0] md, input logic [31:0] fg,
                                  input logic [31:0] wm, input logic [31:0] ls,
                                  input logic [31:0] mn, input logic [31:0] sp);
    wait_drained();
    write_reg(REG_MOD_DEPTH, md);
    write_reg(REG_FEEDBACK_GAIN, fg);
    write_reg(REG_WET_MIX, wm);
    write_reg(REG_LFO_STEP, ls);
    write_reg(REG_MIN_DELAY, mn);
    write_reg(REG_DELAY_SPAN, sp);
    cfg_valid <= 1'b0;
    setting_count++;
  endtask

  // sender: takes requests from the pending queue, predicts on accept
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_outs.push_back(chorus_predict(channel_select, sample_in));
        accepted_total++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_wait > 0) begin
          in_valid <= 1'b0;
          tx_wait--;
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          channel_select <= next_req.ch;
          sample_in <= next_req.smp;
          tx_wait = tx_gaps ? idle_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_outs.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", sample_out);
          fail_count++;
        end else begin
          want = expected_outs.pop_front();
          if (sample_out !== want) begin
            if (fail_count < 10)
              $display("sample_out mismatch on result %0d: expected %h got %h",
                       results_seen, want, sample_out);
            fail_count++;
          end
          results_seen++;
        end
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end else begin
        out_stall <= 1'b0;
        if (rx_gaps) stall_run = idle_len();
      end
    end
  end

  // long output hold while requests keep coming, to back the block up
  initial begin : output_hold
    wait (accepted_total >= 80);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // overall time limit
  initial begin : watchdog
    #10000000;
    $display("tb_stereo_chorus_delay NOT OK");
    $finish;
  end

  initial begin : stimulus
    int k;
    logic signed [31:0] s;
    // model reset state
    for (k = 0; k < RING_LEN; k++) begin
      ring[0][k] = '0;
      ring[1][k] = '0;
    end
    wptr[0] = 0;
    wptr[1] = 0;
    smooth[0] = '0;
    smooth[1] = '0;
    lfo_phase[0] = PHASE_LEFT_RST;
    lfo_phase[1] = PHASE_RIGHT_RST;
    md_r = MOD_DEPTH_RST;
    fg_r = FEEDBACK_GAIN_RST;
    wet_r = WET_MIX_RST;
    step_r = LFO_STEP_RST;
    mind_r = MIN_DELAY_RST;
    span_r = DELAY_SPAN_RST;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset defaults, extreme samples on both channels
    queue_req(1'b0, Q31_MAX);
    queue_req(1'b1, Q31_MIN);
    queue_req(1'b0, '0);
    queue_req(1'b1, -32'sd1);
    queue_req(1'b0, 32'sd1);
    queue_req(1'b1, 32'sh40000000);

    // directed: full gains, very short delays, lfo jumping a quarter per sample
    settle_and_write(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h4000, 1, 2);
    for (k = 0; k < 16; k++) begin
      case (k % 4)
        0:       s = Q31_MAX;
        1:       s = Q31_MIN;
        2:       s = -32'sd1;
        default: s = 32'sh12345678;
      endcase
      queue_req(1'(k / 4 % 2), s);
    end

    // random: random settings with short delays
    settle_and_write($urandom, $urandom, $urandom_range(0, 32'h7FFFFFFF),
                     $urandom_range(1, 64), $urandom_range(1, 40), $urandom_range(0, 40));
    queue_random(PHASE_ITEMS);

    // random: negative full-scale gains, no wet share, zero minimum delay
    settle_and_write(32'h80000000, 32'h80000000, 32'h0, 32'hFFFF, 0, 1023);
    queue_random(PHASE_ITEMS);

    // random: longest delays, tap clamped to the ring, sender never idles
    tx_gaps <= 1'b0;
    settle_and_write(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1023, 1023);
    queue_random(PHASE_ITEMS);

    // random: every register with random full-width data, receiver never stalls
    tx_gaps <= 1'b1;
    rx_gaps <= 1'b0;
    wait_drained();
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    settle_and_write($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    queue_random(PHASE_ITEMS);

    // random: short delays with no idling on either side
    tx_gaps <= 1'b0;
    settle_and_write($urandom, $urandom_range(0, 32'h7FFFFFFF),
                     $urandom_range(0, 32'h7FFFFFFF), $urandom_range(1, 2000),
                     $urandom_range(1, 16), $urandom_range(0, 16));
    queue_random(PHASE_ITEMS);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_outs.size() != 0) begin
      $display("%0d results never arrived", expected_outs.size());
      fail_count += expected_outs.size();
    end

    $display("%0d samples sent over %0d register settings, %0d results checked",
             accepted_total, setting_count + 1, results_seen);
    $display("output held off for %0d cycles once, %0d failures", HOLD_CYCLES, fail_count);
    if (fail_count == 0) begin
      $display("tb_stereo_chorus_delay OK");
    end else begin
      $display("tb_stereo_chorus_delay NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
rtl/scd_pkg.sv
rtl/stereo_chorus_delay.sv
sim/tb_stereo_chorus_delay.sv
